// File: design/isom_pkg.sv
package isom_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 1024;
	localparam int FRACTION_BITS = 8;
	localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
	localparam int PHASE_BITS    = INDEX_BITS + FRACTION_BITS;
	localparam int QUARTER       = TABLE_ENTRIES / 4;

	// Field and datapath widths.
	localparam int SAMPLE_IN_BITS  = 24;
	localparam int SAMPLE_OUT_BITS = 25;
	localparam int ROM_BITS        = 16;
	localparam int AMP_BITS        = 16;
	localparam int STEP_BITS       = 10;
	localparam int PROD_BITS       = ROM_BITS + FRACTION_BITS + 1;
	localparam int TERM_BITS       = PROD_BITS - FRACTION_BITS;
	localparam int MIX_BITS        = TERM_BITS + 1;
	localparam int AMP_PROD_BITS   = MIX_BITS + AMP_BITS + 1;
	localparam int TONE_BITS       = AMP_PROD_BITS - 16;

	// Configuration port.
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [AMP_BITS-1:0]  AMP_RESET  = AMP_BITS'(32767);
	localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(55);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TONE_AMPLITUDE = 1'b0,
		REG_PHASE_STEP     = 1'b1
	} cfg_reg_t;

	typedef logic signed [SAMPLE_IN_BITS-1:0]  sample_in_t;
	typedef logic signed [SAMPLE_OUT_BITS-1:0] sample_out_t;
	typedef logic [CFG_IDX_BITS-1:0]           cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]          cfg_data_t;
	typedef logic signed [ROM_BITS-1:0]        rom_word_t;
	typedef rom_word_t                         sine_rom_t [TABLE_ENTRIES];

	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam longint          SINE_PEAK = 32767;

	// Unsigned quotient by shift and subtract; used only while building the table.
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(32767 * sin(x)) for x in Q30 on the first quadrant, by Taylor series.
	function automatic longint quarter_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned den;
		longint          sum;
		longint          v;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 15; n++) begin
			den  = 64'((2 * n) * (2 * n + 1));
			term = udiv((term * x2) >> 30, den);
			if ((n & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * SINE_PEAK + (longint'(1) <<< 29)) >>> 30;
		if (v > SINE_PEAK) begin
			v = SINE_PEAK;
		end
		return v;
	endfunction

	// One sine period, mirrored from the first quadrant; evaluated at elaboration.
	function automatic sine_rom_t build_rom();
		sine_rom_t       rom;
		longint unsigned q;
		longint unsigned r;
		longint unsigned pos;
		longint          mag;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			q   = longint'(k) >> (INDEX_BITS - 2);
			r   = longint'(k) & longint'(QUARTER - 1);
			pos = ((q & 1) != 0) ? (longint'(QUARTER) - r) : r;
			mag = quarter_sine((PI_Q30 * pos) >> (INDEX_BITS - 1));
			rom[k] = ((q & 2) != 0) ? ROM_BITS'(-mag) : ROM_BITS'(mag);
		end
		return rom;
	endfunction

endpackage

// File: design/isom_if.sv
// Input sample channel.
interface isom_in_if;
	import isom_pkg::*;
	logic       valid;
	logic       ready;
	sample_in_t sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface isom_out_if;
	import isom_pkg::*;
	logic        valid;
	logic        ready;
	sample_out_t sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// Configuration write channel.
interface isom_cfg_if;
	import isom_pkg::*;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/interpolated_sine_oscillator_mixer_top.sv
// The sequencer accepts one sample at a time and takes no new input until the last result
// leaves the OUT step; each sample passes through RD1, MUL1, MUL0, SUM, AMP and OUT, paced by the
// single sine ROM read port (two reads) and the separate multiply steps; OUT waits while the output stalls.
// Reset (arst_n low, asynchronous): phase cleared, amplitude 32767, step 55, output empty.
// The sine ROM is constant and needs no clearing pass.
module interpolated_sine_oscillator_mixer_top (
	input logic         clk,
	input logic         arst_n,
	isom_in_if.sink     audio_in,
	isom_out_if.source  audio_out,
	isom_cfg_if.sink    cfg
);
	import isom_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD1  = 7'b0000010,
		ST_MUL1 = 7'b0000100,
		ST_MUL0 = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_AMP  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	localparam sine_rom_t SINE_ROM = build_rom();

	state_t                        state_q;
	logic [AMP_BITS-1:0]           amp_q;
	logic [STEP_BITS-1:0]          step_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic [PHASE_BITS-1:0]         phase_nxt;
	logic [INDEX_BITS-1:0]         rd_addr;
	logic [INDEX_BITS-1:0]         idx;
	logic [FRACTION_BITS-1:0]      frac;
	logic signed [FRACTION_BITS:0] frac_w;
	logic signed [FRACTION_BITS:0] inv_w;
	rom_word_t                     rom_q;
	rom_word_t                     e0_q;
	sample_in_t                    sample_q;
	logic signed [PROD_BITS-1:0]   p1_q;
	logic signed [PROD_BITS-1:0]   p0_q;
	logic signed [MIX_BITS-1:0]    mix_q;
	logic signed [AMP_PROD_BITS-1:0] amp_prod;
	logic signed [TONE_BITS-1:0]   tone_q;
	logic                          out_valid_q;
	sample_out_t                   out_q;
	logic                          in_xfer;
	logic                          out_free;

	assign audio_in.ready  = (state_q == ST_IDLE);
	assign in_xfer         = audio_in.valid && audio_in.ready;
	assign out_free        = !out_valid_q || audio_out.ready;
	assign audio_out.valid = out_valid_q;
	assign audio_out.sample_out = out_q;
	assign cfg.ready       = 1'b1;

	// Phase split into table index and interpolation fraction.
	assign phase_nxt = phase_q + PHASE_BITS'(step_q);
	assign idx       = phase_q[PHASE_BITS-1:FRACTION_BITS];
	assign frac      = phase_q[FRACTION_BITS-1:0];
	assign frac_w    = $signed({1'b0, frac});
	assign inv_w     = $signed({1'b0, ~frac});

	// The first read goes out with the input transfer, the second in the RD1 step that follows it.
	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = phase_nxt[PHASE_BITS-1:FRACTION_BITS];
			ST_RD1:  rd_addr = idx + INDEX_BITS'(1);
			default: rd_addr = idx;
		endcase
	end

	// Sine ROM with a registered read.
	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q  <= AMP_RESET;
			step_q <= STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TONE_AMPLITUDE: amp_q  <= cfg.data[AMP_BITS-1:0];
				REG_PHASE_STEP:     step_q <= cfg.data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and phase accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills in the output step and empties on its transfer.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (audio_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						phase_q <= phase_nxt;
						state_q <= ST_RD1;
					end
				end
				ST_RD1:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_AMP;
				ST_AMP:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Amplitude product; the shift by 16 is the upper slice.
	assign amp_prod = mix_q * $signed({1'b0, amp_q});

	// Datapath registers, loaded in the step that owns them.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= audio_in.sample_in;
		end
		if (state_q == ST_RD1) begin
			e0_q <= rom_q;
		end
		if (state_q == ST_MUL1) begin
			p1_q <= rom_q * frac_w;
		end
		if (state_q == ST_MUL0) begin
			p0_q <= e0_q * inv_w;
		end
		if (state_q == ST_SUM) begin
			mix_q <= $signed({p1_q[PROD_BITS-1], p1_q[PROD_BITS-1:FRACTION_BITS]})
				+ $signed({p0_q[PROD_BITS-1], p0_q[PROD_BITS-1:FRACTION_BITS]});
		end
		if (state_q == ST_AMP) begin
			tone_q <= amp_prod[AMP_PROD_BITS-1:16];
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q <= $signed({sample_q[SAMPLE_IN_BITS-1], sample_q})
				+ $signed({{(SAMPLE_OUT_BITS-TONE_BITS){tone_q[TONE_BITS-1]}}, tone_q});
		end
	end

endmodule

// File: design/isom_checker.sv
module isom_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input isom_pkg::sample_out_t sample_out,
	input logic                 cfg_ready
);
	import isom_pkg::*;

	// A waiting result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output result changed or dropped while stalled");

	// One sample at a time: the input closes right after a transfer.
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input stayed open after a transfer");

	// A result cannot appear in the cycle after its input transfer.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// Configuration writes are always taken.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind interpolated_sine_oscillator_mixer_top isom_checker u_isom_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (audio_in.valid),
	.in_ready   (audio_in.ready),
	.out_valid  (audio_out.valid),
	.out_ready  (audio_out.ready),
	.sample_out (audio_out.sample_out),
	.cfg_ready  (cfg.ready)
);

// File: test/interpolated_sine_oscillator_mixer_top_tb.sv
`timescale 1ns / 100ps

module interpolated_sine_oscillator_mixer_top_tb;
	import isom_pkg::*;

	localparam int          RANDOM_ITEMS = 1880;
	localparam int          CALM_ITEMS   = 250;
	localparam int          HOLD_AT_ITEM = 700;
	localparam int          LONG_HOLD    = 300;
	localparam int          SETTLE_WAIT  = 8;
	localparam int          TAIL_WAIT    = 20;
	localparam int unsigned CYCLE_LIMIT  = 500000;

	// Predicts each mixed output sample from the accepted input samples.
	class mixed_sample_predictor;
		localparam longint unsigned PI_FIXED = 64'd3373259426;
		localparam longint          PEAK     = 32767;
		localparam longint          FRAC_MAX = (64'sd1 <<< FRACTION_BITS) - 1;

		rom_word_t              sine_table [TABLE_ENTRIES];
		logic [PHASE_BITS-1:0]  phase;
		logic [AMP_BITS-1:0]    amplitude;
		logic [STEP_BITS-1:0]   step;
		sample_out_t            pending_mixes [$];
		int                     errors;
		int                     checked;

		function new();
			fill_table();
			phase     = '0;
			amplitude = 16'd32767;
			step      = 10'd55;
			errors    = 0;
			checked   = 0;
		endfunction

		// Magnitude of 32767 * sin(angle), angle in Q30 on the first quadrant.
		function longint sine_magnitude(longint unsigned angle);
			longint unsigned sq;
			longint unsigned term;
			longint unsigned divisor;
			longint          acc;
			longint          rounded;
			int              k;
			sq   = (angle * angle) >> 30;
			term = angle;
			acc  = longint'(angle);
			for (k = 1; k <= 15; k++) begin
				divisor = (2 * k) * (2 * k + 1);
				term    = ((term * sq) >> 30) / divisor;
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rounded = (acc * PEAK + (64'sd1 <<< 29)) >>> 30;
			if (rounded > PEAK) begin
				rounded = PEAK;
			end
			return rounded;
		endfunction

		// The table holds one period, mirrored from the first quadrant.
		function void fill_table();
			longint unsigned quadrant;
			longint unsigned offset;
			longint unsigned pos;
			longint unsigned quarter;
			longint          mag;
			int              k;
			quarter = TABLE_ENTRIES / 4;
			for (k = 0; k < TABLE_ENTRIES; k++) begin
				quadrant = k / quarter;
				offset   = k % quarter;
				pos      = quadrant[0] ? (quarter - offset) : offset;
				mag      = sine_magnitude((PI_FIXED * pos) / (2 * quarter));
				sine_table[k] = quadrant[1] ? rom_word_t'(-mag) : rom_word_t'(mag);
			end
		endfunction

		function void write_register(cfg_index_t idx, cfg_data_t value);
			case (idx)
				REG_TONE_AMPLITUDE: amplitude = value[AMP_BITS-1:0];
				REG_PHASE_STEP:     step = value[STEP_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Advance the phase, interpolate the tone and add it to the sample.
		function void note_sample(sample_in_t sample);
			logic [INDEX_BITS-1:0]    idx;
			logic [INDEX_BITS-1:0]    next_idx;
			logic [FRACTION_BITS-1:0] frac;
			longint                   lo;
			longint                   hi;
			longint                   blend;
			longint                   tone;
			longint                   total;
			phase    = phase + PHASE_BITS'(step);
			idx      = phase[PHASE_BITS-1:FRACTION_BITS];
			frac     = phase[FRACTION_BITS-1:0];
			next_idx = idx + 1'b1;
			lo       = sine_table[idx];
			hi       = sine_table[next_idx];
			// The weights add up to one less than a full unit, as specified.
			blend = ((hi * longint'(frac)) >>> FRACTION_BITS)
				+ ((lo * (FRAC_MAX - longint'(frac))) >>> FRACTION_BITS);
			tone  = (blend * longint'(amplitude)) >>> 16;
			total = longint'(sample) + tone;
			pending_mixes.push_back(sample_out_t'(total));
		endfunction

		function void check_mix(sample_out_t got);
			sample_out_t want;
			if (pending_mixes.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: output sample %0d arrived with none expected", got);
				end
				return;
			end
			want = pending_mixes.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d sample_out expected %0d actual %0d",
						checked, want, got);
				end
			end
			checked++;
		endfunction

		function int pending();
			return pending_mixes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	isom_in_if  in_ch ();
	isom_out_if out_ch ();
	isom_cfg_if cfg_ch ();

	mixed_sample_predictor mix_model;

	bit          quiet        = 1'b0;
	bit          hold_request = 1'b0;
	int          items_sent   = 0;
	int          register_writes = 0;
	int          settings_used = 0;
	int unsigned cycle_count  = 0;

	interpolated_sine_oscillator_mixer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio_in (in_ch),
		.audio_out(out_ch),
		.cfg      (cfg_ch)
	);

	always #5 clk = ~clk;

	// Note every transfer on the three channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				mix_model.write_register(cfg_ch.index, cfg_ch.data);
			end
			if (in_ch.valid && in_ch.ready) begin
				mix_model.note_sample(in_ch.sample_in);
			end
			if (out_ch.valid && out_ch.ready) begin
				mix_model.check_mix(out_ch.sample_out);
			end
		end
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("FAIL interpolated_sine_oscillator_mixer_top");
			$finish;
		end
	end

	// Output ready: random stall bursts, one long hold-off, none near the end.
	initial begin : output_ready
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 40)) @(negedge clk);
			end
		end
	end

	// Offer one sample and hold it until its transfer; returns at a falling edge.
	task automatic send_sample(input sample_in_t sample);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= sample;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Write one register; the caller lowers valid after its last write.
	task automatic write_register(input cfg_reg_t which, input cfg_data_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		register_writes++;
	endtask

	task automatic program_tone(input cfg_data_t amp_word, input cfg_data_t step_word);
		if ($urandom_range(0, 1) == 0) begin
			write_register(REG_TONE_AMPLITUDE, amp_word);
			write_register(REG_PHASE_STEP, step_word);
		end else begin
			write_register(REG_PHASE_STEP, step_word);
			write_register(REG_TONE_AMPLITUDE, amp_word);
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Stop offering input and let every expected sample come out.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (mix_model.pending() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	function automatic sample_in_t random_sample();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return sample_in_t'($urandom_range(0, 31)) - 24'sd16;
			default: return sample_in_t'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int        random_items;
		int        run_len;
		int        n;
		cfg_data_t amp_word;
		cfg_data_t step_word;
		random_items     = 0;
		in_ch.valid      = 1'b0;
		in_ch.sample_in  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_TONE_AMPLITUDE;
		cfg_ch.data      = '0;
		mix_model        = new();
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings with the sample extremes.
		send_sample(24'sd0);
		send_sample(24'sh7FFFFF);
		send_sample(24'sh800000);
		send_sample(-24'sd1);
		send_sample(24'sd1);

		// Full gain and the largest step, given with every data bit set.
		settle();
		program_tone(16'hFFFF, 16'hFFFF);
		send_sample(24'sh7FFFFF);
		send_sample(24'sh800000);
		send_sample(24'sh555555);
		send_sample(24'shAAAAAA);
		send_sample(24'sd0);

		// Zero amplitude: output follows the input.
		settle();
		program_tone(16'h0000, 16'd300);
		send_sample(24'sh7FFFFF);
		send_sample(24'sh800000);
		send_sample(24'sd12345);

		// Zero step: the tone holds still.
		settle();
		program_tone(16'hFFFF, 16'h0000);
		send_sample(24'sh800000);
		send_sample(24'sh7FFFFF);
		send_sample(24'sd0);

		// Smallest nonzero step and gain.
		settle();
		program_tone(16'h0001, 16'h0001);
		send_sample(-24'sd7);
		send_sample(24'sd7);
		send_sample(24'sh800000);

		// Random settings, each followed by a run of random samples.
		while (random_items < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 5))
				0: amp_word = 16'h0000;
				1: amp_word = 16'hFFFF;
				default: amp_word = cfg_data_t'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: step_word = 16'h0000;
				1: step_word = 16'h0001;
				2: step_word = 16'h03FF;
				3: step_word = cfg_data_t'($urandom);
				4: step_word = cfg_data_t'($urandom_range(1, 64));
				default: step_word = cfg_data_t'($urandom_range(1, 1023));
			endcase
			program_tone(amp_word, step_word);
			run_len = $urandom_range(40, 200);
			for (n = 0; n < run_len && random_items < RANDOM_ITEMS; n++) begin
				if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
					quiet = 1'b1;
				end
				if (random_items == HOLD_AT_ITEM) begin
					hold_request = 1'b1;
				end
				send_sample(random_sample());
				random_items++;
			end
		end

		// Drain and report.
		in_ch.valid <= 1'b0;
		while (mix_model.pending() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		$display("Run covered %0d samples under %0d tone settings (%0d register writes),",
			items_sent, settings_used + 1, register_writes);
		$display("with %0d mixed samples checked against the interpolated tone.",
			mix_model.checked);
		if (mix_model.errors == 0 && mix_model.pending() == 0) begin
			$display("PASS interpolated_sine_oscillator_mixer_top");
		end else begin
			$display("Failures: %0d, samples still expected: %0d",
				mix_model.errors, mix_model.pending());
			$display("FAIL interpolated_sine_oscillator_mixer_top");
		end
		$finish;
	end

endmodule
